### src/gf2md_pkg.sv
// Shared types, codes and constants of the GF(2^32) multiply / divide unit.
`timescale 1ns / 1ps
`default_nettype none

package gf2md_pkg;

	// Field and polynomial widths
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned POLY_W  = 64;
	localparam int unsigned DEG_W   = 6;
	localparam int unsigned CNT_W   = 6;

	// Modulus low word after reset (CRC-32 polynomial, x^32 implicit)
	localparam logic [FIELD_W-1:0] MODULUS_LOW_RESET = 32'h04C1_1DB7;

	// Operation codes; code 3 means nothing and yields a zero result
	localparam logic [1:0] FUNC_MUL = 2'd0;
	localparam logic [1:0] FUNC_DIV = 2'd1;
	localparam logic [1:0] FUNC_INV = 2'd2;

	// Step counts of the iterative units (last step index)
	localparam logic [CNT_W-1:0] RED_LAST      = 6'd31;
	localparam logic [CNT_W-1:0] MUL_LAST_FULL = 6'd63;
	localparam logic [CNT_W-1:0] MUL_LAST_HALF = 6'd31;

	// Degrees loaded at the start of the Euclid phase
	localparam logic [DEG_W-1:0] DEG_U_INIT = 6'd31;
	localparam logic [DEG_W-1:0] DEG_V_INIT = 6'd32;

	// Source of the output register
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ACC,
		RES_RED
	} res_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_B,
		ST_EUC_INIT,
		ST_EUC_NORM,
		ST_EUC_STEP,
		ST_RED_G,
		ST_MUL_LOAD,
		ST_MUL,
		ST_DONE_ACC,
		ST_DONE_RED,
		ST_DONE_FAIL,
		ST_DONE_NONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     load;
		logic     red_step;
		logic     red_load_g;
		logic     euc_init;
		logic     norm_step;
		logic     euc_step;
		logic     mul_load_inv;
		logic     mul_step;
		logic     out_write;
		res_sel_t res_sel;
		logic     flag;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic u_zero;
		logic u_top;
		logic v_one;
	} dp_stat_t;

endpackage

`default_nettype wire

### src/gf2md_dpath.sv
// Datapath: reducer, polynomial Euclid step, bit-serial multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module gf2md_dpath (
	input  wire logic                             clk,
	input  wire logic [gf2md_pkg::FIELD_W-1:0]    modulus_low,
	input  wire logic [gf2md_pkg::FIELD_W-1:0]    operand_a,
	input  wire logic [gf2md_pkg::POLY_W-1:0]     operand_b,
	input  wire gf2md_pkg::dp_cmd_t               cmd,
	output gf2md_pkg::dp_stat_t                   stat,
	output logic [gf2md_pkg::FIELD_W-1:0]         result,
	output logic                                  no_inverse
);

	logic [gf2md_pkg::FIELD_W-1:0] a_q;
	logic [gf2md_pkg::FIELD_W-1:0] acc_q;
	logic [gf2md_pkg::POLY_W-1:0]  mop_q;
	logic [gf2md_pkg::POLY_W-1:0]  red_q;
	logic [gf2md_pkg::FIELD_W:0]   u_q;
	logic [gf2md_pkg::FIELD_W:0]   v_q;
	logic [gf2md_pkg::POLY_W-1:0]  g1_q;
	logic [gf2md_pkg::POLY_W-1:0]  g2_q;
	logic [gf2md_pkg::DEG_W-1:0]   du_q;
	logic [gf2md_pkg::DEG_W-1:0]   dv_q;
	logic [gf2md_pkg::FIELD_W-1:0] res_q;
	logic                          flag_q;

	logic [gf2md_pkg::FIELD_W:0]   m_full;
	logic [gf2md_pkg::POLY_W-1:0]  red_fb;
	logic [gf2md_pkg::POLY_W-1:0]  red_next;
	logic [gf2md_pkg::FIELD_W-1:0] acc_next;

	logic                          swap;
	logic [gf2md_pkg::FIELD_W:0]   us;
	logic [gf2md_pkg::FIELD_W:0]   vs;
	logic [gf2md_pkg::POLY_W-1:0]  g1s;
	logic [gf2md_pkg::POLY_W-1:0]  g2s;
	logic [gf2md_pkg::DEG_W-1:0]   dus;
	logic [gf2md_pkg::DEG_W-1:0]   dvs;
	logic [gf2md_pkg::DEG_W-1:0]   shamt;
	logic [gf2md_pkg::FIELD_W:0]   u_next;
	logic [gf2md_pkg::POLY_W-1:0]  g1_next;

	assign m_full = {1'b1, modulus_low};

	// Reducer: look at the top bit, cancel it with the modulus, shift up
	assign red_fb   = red_q[gf2md_pkg::POLY_W-1]
		? {m_full, {(gf2md_pkg::POLY_W - gf2md_pkg::FIELD_W - 1){1'b0}}}
		: '0;
	assign red_next = (red_q ^ red_fb) << 1;

	// Multiplier: double, reduce, add a when the current bit of b is set
	assign acc_next = {acc_q[gf2md_pkg::FIELD_W-2:0], 1'b0}
		^ (acc_q[gf2md_pkg::FIELD_W-1] ? modulus_low : '0)
		^ (mop_q[gf2md_pkg::POLY_W-1] ? a_q : '0);

	// Euclid step: order by degree, then cancel the leading term of u
	always_comb begin
		swap    = du_q < dv_q;
		us      = swap ? v_q : u_q;
		vs      = swap ? u_q : v_q;
		g1s     = swap ? g2_q : g1_q;
		g2s     = swap ? g1_q : g2_q;
		dus     = swap ? dv_q : du_q;
		dvs     = swap ? du_q : dv_q;
		shamt   = dus - dvs;
		u_next  = us ^ (vs << shamt);
		g1_next = g1s ^ (g2s << shamt);
	end

	// Multiplier operand and accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= operand_a;
			mop_q <= operand_b;
			acc_q <= '0;
		end else if (cmd.mul_load_inv) begin
			mop_q <= {red_q[gf2md_pkg::POLY_W-1 -: gf2md_pkg::FIELD_W],
				{(gf2md_pkg::POLY_W - gf2md_pkg::FIELD_W){1'b0}}};
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			mop_q <= mop_q << 1;
			acc_q <= acc_next;
		end
	end

	// Reducer shift register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			red_q <= operand_b;
		end else if (cmd.red_load_g) begin
			red_q <= g2_q;
		end else if (cmd.red_step) begin
			red_q <= red_next;
		end
	end

	// Euclid registers
	always_ff @(posedge clk) begin
		if (cmd.euc_init) begin
			u_q  <= {1'b0, red_q[gf2md_pkg::POLY_W-1 -: gf2md_pkg::FIELD_W]};
			v_q  <= m_full;
			g1_q <= gf2md_pkg::POLY_W'(1);
			g2_q <= '0;
			du_q <= gf2md_pkg::DEG_U_INIT;
			dv_q <= gf2md_pkg::DEG_V_INIT;
		end else if (cmd.euc_step) begin
			u_q  <= u_next;
			v_q  <= vs;
			g1_q <= g1_next;
			g2_q <= g2s;
			du_q <= dus;
			dv_q <= dvs;
		end else if (cmd.norm_step) begin
			du_q <= du_q - gf2md_pkg::DEG_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			unique case (cmd.res_sel)
				gf2md_pkg::RES_ACC: res_q <= acc_q;
				gf2md_pkg::RES_RED: res_q <= red_q[gf2md_pkg::POLY_W-1 -: gf2md_pkg::FIELD_W];
				default:            res_q <= '0;
			endcase
			flag_q <= cmd.flag;
		end
	end

	assign stat.u_zero = (u_q == '0);
	assign stat.u_top  = u_q[du_q];
	assign stat.v_one  = (v_q == (gf2md_pkg::FIELD_W+1)'(1));

	assign result     = res_q;
	assign no_inverse = flag_q;

endmodule

`default_nettype wire

### src/gf2md_ctrl.sv
// Controller: sequences reduce, Euclid, multiply and output phases of one item.
`timescale 1ns / 1ps
`default_nettype none

module gf2md_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          func,
	input  wire gf2md_pkg::dp_stat_t stat,
	output gf2md_pkg::dp_cmd_t       cmd,
	output logic                     busy,
	output logic                     done
);

	gf2md_pkg::state_t              state_q, state_d;
	logic [gf2md_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [1:0]                     func_q, func_d;
	logic                           done_q, done_d;
	logic [gf2md_pkg::CNT_W-1:0]    mul_last;

	assign mul_last = (func_q == gf2md_pkg::FUNC_DIV) ? gf2md_pkg::MUL_LAST_HALF
		: gf2md_pkg::MUL_LAST_FULL;

	// State, step counter, operation and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gf2md_pkg::ST_IDLE;
			cnt_q   <= '0;
			func_q  <= gf2md_pkg::FUNC_MUL;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			func_q  <= func_d;
			done_q  <= done_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		func_d  = func_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			gf2md_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					func_d   = func;
					unique case (func)
						gf2md_pkg::FUNC_MUL: state_d = gf2md_pkg::ST_MUL;
						gf2md_pkg::FUNC_DIV: state_d = gf2md_pkg::ST_RED_B;
						gf2md_pkg::FUNC_INV: state_d = gf2md_pkg::ST_RED_B;
						default:             state_d = gf2md_pkg::ST_DONE_NONE;
					endcase
				end
			end
			gf2md_pkg::ST_RED_B: begin
				cmd.red_step = 1'b1;
				cnt_d        = cnt_q + gf2md_pkg::CNT_W'(1);
				if (cnt_q == gf2md_pkg::RED_LAST) begin
					state_d = gf2md_pkg::ST_EUC_INIT;
				end
			end
			gf2md_pkg::ST_EUC_INIT: begin
				cmd.euc_init = 1'b1;
				state_d      = gf2md_pkg::ST_EUC_NORM;
			end
			gf2md_pkg::ST_EUC_NORM: begin
				// u gone to zero ends the loop; v then holds the gcd
				priority if (stat.u_zero) begin
					if (stat.v_one) begin
						cmd.red_load_g = 1'b1;
						cnt_d          = '0;
						state_d        = gf2md_pkg::ST_RED_G;
					end else begin
						state_d = gf2md_pkg::ST_DONE_FAIL;
					end
				end else if (stat.u_top) begin
					state_d = gf2md_pkg::ST_EUC_STEP;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			gf2md_pkg::ST_EUC_STEP: begin
				cmd.euc_step = 1'b1;
				state_d      = gf2md_pkg::ST_EUC_NORM;
			end
			gf2md_pkg::ST_RED_G: begin
				cmd.red_step = 1'b1;
				cnt_d        = cnt_q + gf2md_pkg::CNT_W'(1);
				if (cnt_q == gf2md_pkg::RED_LAST) begin
					state_d = (func_q == gf2md_pkg::FUNC_DIV) ? gf2md_pkg::ST_MUL_LOAD
						: gf2md_pkg::ST_DONE_RED;
				end
			end
			gf2md_pkg::ST_MUL_LOAD: begin
				cmd.mul_load_inv = 1'b1;
				cnt_d            = '0;
				state_d          = gf2md_pkg::ST_MUL;
			end
			gf2md_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + gf2md_pkg::CNT_W'(1);
				if (cnt_q == mul_last) begin
					state_d = gf2md_pkg::ST_DONE_ACC;
				end
			end
			gf2md_pkg::ST_DONE_ACC: begin
				cmd.out_write = 1'b1;
				cmd.res_sel   = gf2md_pkg::RES_ACC;
				done_d        = 1'b1;
				state_d       = gf2md_pkg::ST_IDLE;
			end
			gf2md_pkg::ST_DONE_RED: begin
				cmd.out_write = 1'b1;
				cmd.res_sel   = gf2md_pkg::RES_RED;
				done_d        = 1'b1;
				state_d       = gf2md_pkg::ST_IDLE;
			end
			gf2md_pkg::ST_DONE_FAIL: begin
				cmd.out_write = 1'b1;
				cmd.res_sel   = gf2md_pkg::RES_ZERO;
				cmd.flag      = 1'b1;
				done_d        = 1'b1;
				state_d       = gf2md_pkg::ST_IDLE;
			end
			gf2md_pkg::ST_DONE_NONE: begin
				cmd.out_write = 1'b1;
				cmd.res_sel   = gf2md_pkg::RES_ZERO;
				done_d        = 1'b1;
				state_d       = gf2md_pkg::ST_IDLE;
			end
			default: begin
				state_d = gf2md_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != gf2md_pkg::ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

### src/gf2_32_mul_div_unit.sv
// Top level: modulus register, controller and datapath of the GF(2^32) unit.
// Multiply: 64 steps of the bit-serial multiplier, then the done beat.
// Invert: 32 reducer steps on b, then the Euclid loop of cancellations and dropped degrees,
// then 32 reducer steps on the cofactor.
// Divide: as invert, then the inverse is multiplied by a; an unused code yields a zero result.
// One item at a time: busy stays high from accept until the done beat is driven.
// arst_n clears control and loads the modulus with the CRC-32 polynomial; no stall exists.
`timescale 1ns / 1ps
`default_nettype none

module gf2_32_mul_div_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    func,
	input  wire logic [gf2md_pkg::FIELD_W-1:0] operand_a,
	input  wire logic [gf2md_pkg::POLY_W-1:0]  operand_b,
	output logic                               done,
	output logic [gf2md_pkg::FIELD_W-1:0]      result,
	output logic                               no_inverse,
	input  wire logic                          cfg_wen,
	input  wire logic [gf2md_pkg::FIELD_W-1:0] cfg_wdata
);

	logic [gf2md_pkg::FIELD_W-1:0] modulus_low_q;
	gf2md_pkg::dp_cmd_t            cmd;
	gf2md_pkg::dp_stat_t           stat;

	// Hold the modulus low word; the user must write it only while idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_low_q <= gf2md_pkg::MODULUS_LOW_RESET;
		end else if (cfg_wen) begin
			modulus_low_q <= cfg_wdata;
		end
	end

	gf2md_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gf2md_dpath u_dpath (
		.clk         (clk),
		.modulus_low (modulus_low_q),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result),
		.no_inverse  (no_inverse)
	);

endmodule

`default_nettype wire

### src/gf2md_checker.sv
// Port-level checker of the GF(2^32) unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gf2md_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [1:0]                    func,
	input wire logic                          done,
	input wire logic [gf2md_pkg::FIELD_W-1:0] result,
	input wire logic                          no_inverse
);

	// An accepted beat makes the unit busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// The done beat is shown only once the unit is free again
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done beat while busy");

	// A failed inverse returns zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_inverse) |-> (result == '0))
		else $error("no_inverse with nonzero result");

	// An unused operation code finishes with a clean zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func != gf2md_pkg::FUNC_MUL && func != gf2md_pkg::FUNC_DIV
			&& func != gf2md_pkg::FUNC_INV)
		|-> ##2 (done && result == '0 && !no_inverse))
		else $error("unused code not finished as empty result");

endmodule

bind gf2_32_mul_div_unit gf2md_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.done       (done),
	.result     (result),
	.no_inverse (no_inverse)
);

`default_nettype wire
